@@ design/iop_pkg.sv @@
`timescale 1ns / 1ps

package iop_pkg;

  // Geometry of the coverage store
  localparam int unsigned TIME_SLOTS = 65536;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SLOT_BITS  = $clog2(TIME_SLOTS);
  localparam int unsigned POS_BITS   = SLOT_BITS + 1;

  // Running prefix sum of the delta store, modulo 2^ACC_BITS
  localparam int unsigned ACC_BITS   = COUNT_BITS + 16;

  // Fixed port widths
  localparam int unsigned START_BITS = 16;
  localparam int unsigned END_BITS   = 17;
  localparam int unsigned CMP_BITS   = 24;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_ADD_START,
    ST_SUB_END,
    ST_SCAN,
    ST_WAIT,
    ST_FINISH,
    ST_EMIT
  } iop_state_e;

  // One slot of the scan stream into the plateau tracker
  typedef struct packed {
    logic                  valid;
    logic                  finish;
    logic [SLOT_BITS-1:0]  slot;
    logic [COUNT_BITS-1:0] count;
  } iop_track_t;

endpackage

@@ design/iop_delta_mem.sv @@
`timescale 1ns / 1ps

module iop_delta_mem (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [iop_pkg::SLOT_BITS-1:0]       waddr_i,
  input  logic [iop_pkg::ACC_BITS-1:0]        wdata_i,
  input  logic [iop_pkg::SLOT_BITS-1:0]       raddr_i,
  output logic [iop_pkg::ACC_BITS-1:0]        rdata_o
);

  logic [iop_pkg::ACC_BITS-1:0] mem_q [iop_pkg::TIME_SLOTS];
  logic [iop_pkg::ACC_BITS-1:0] rdata_q;

  // Read returns the old word when the same address is written in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/iop_plateau.sv @@
`timescale 1ns / 1ps

module iop_plateau (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  iop_pkg::iop_track_t                 trk_i,
  output logic [iop_pkg::COUNT_BITS-1:0]      best_count_o,
  output logic [iop_pkg::SLOT_BITS-1:0]       best_left_o,
  output logic [iop_pkg::POS_BITS-1:0]        best_right_o
);

  logic                              have_q, have_d;
  logic [iop_pkg::COUNT_BITS-1:0]    run_h_q;
  logic [iop_pkg::SLOT_BITS-1:0]     run_left_q;
  logic [iop_pkg::POS_BITS-1:0]      run_len_q;
  logic [iop_pkg::COUNT_BITS-1:0]    best_h_q;
  logic [iop_pkg::SLOT_BITS-1:0]     best_l_q;
  logic [iop_pkg::POS_BITS-1:0]      best_len_q;
  logic [iop_pkg::POS_BITS-1:0]      best_r_q;

  logic                              first_slot;
  logic                              close;
  logic                              take;
  logic [iop_pkg::POS_BITS-1:0]      close_right;

  always_comb begin
    first_slot  = trk_i.valid && (trk_i.slot == '0);
    close       = (trk_i.valid && !first_slot && (trk_i.count != run_h_q)) || trk_i.finish;
    // Higher count wins, then longer run, then the later one
    take        = !have_q || (run_h_q > best_h_q) ||
                  ((run_h_q == best_h_q) && (run_len_q >= best_len_q));
    close_right = trk_i.finish ? iop_pkg::POS_BITS'(iop_pkg::TIME_SLOTS)
                               : iop_pkg::POS_BITS'(trk_i.slot);
    have_d      = have_q;
    if (first_slot) begin
      have_d = 1'b0;
    end else if (close && take) begin
      have_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close && take && !first_slot) begin
      best_h_q   <= run_h_q;
      best_l_q   <= run_left_q;
      best_len_q <= run_len_q;
      best_r_q   <= close_right;
    end
    if (trk_i.valid) begin
      if (first_slot || (trk_i.count != run_h_q)) begin
        run_h_q    <= trk_i.count;
        run_left_q <= trk_i.slot;
        run_len_q  <= iop_pkg::POS_BITS'(1);
      end else begin
        run_len_q  <= run_len_q + iop_pkg::POS_BITS'(1);
      end
    end
  end

  assign best_count_o = best_h_q;
  assign best_left_o  = best_l_q;
  assign best_right_o = best_r_q;

endmodule

@@ design/interval_overlap_peak_finder.sv @@
`timescale 1ns / 1ps

// Interval overlap peak finder. Each transfer on start/busy loads one
// half-open interval [interval_start_i, interval_end_i) into a delta store
// (+1 at the start slot, -1 at the end slot): after the accept, the start
// slot is read, then two read-modify-write updates run over the single
// write port of the store. An interval with last_interval_i set is loaded
// the same way and then starts a scan of all TIME_SLOTS slots, one slot per
// cycle through the store's read port. The scan rebuilds the coverage count
// of each slot as a running sum, saturates it to COUNT_BITS, and tracks the
// plateau (maximal run of equal counts) with the highest count; ties go to
// the longer plateau, then to the later one. The result (peak_count_o,
// peak_left_o, peak_right_o) is shown for exactly one cycle with
// result_valid_o high; the receiver cannot stall it, so it must take the
// result in that cycle. The scan writes zero behind itself, which leaves the
// store clear for the next set. After reset the block runs a clearing pass
// over all TIME_SLOTS slots with busy high. Counts are exact while a set
// holds fewer than 2^ACC_BITS intervals.
module interval_overlap_peak_finder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [iop_pkg::START_BITS-1:0]      interval_start_i,
  input  logic [iop_pkg::END_BITS-1:0]        interval_end_i,
  input  logic                                last_interval_i,
  output logic                                result_valid_o,
  output logic [iop_pkg::COUNT_BITS-1:0]      peak_count_o,
  output logic [iop_pkg::SLOT_BITS-1:0]       peak_left_o,
  output logic [iop_pkg::POS_BITS-1:0]        peak_right_o
);

  iop_pkg::iop_state_e state_q, state_d;

  // Slot counter shared by the clearing pass and the scan
  logic [iop_pkg::SLOT_BITS-1:0] cnt_q, cnt_d;
  logic                          cnt_last;

  // Latched interval
  logic [iop_pkg::START_BITS-1:0] start_q;
  logic [iop_pkg::END_BITS-1:0]   end_q;
  logic                           last_q;
  logic                           nonempty_q;
  logic                           end_in_q;
  logic                           accept;
  logic [iop_pkg::CMP_BITS-1:0]   start_clip;
  logic [iop_pkg::CMP_BITS-1:0]   end_clip;

  // Store port
  logic                          mem_we;
  logic [iop_pkg::SLOT_BITS-1:0] mem_waddr;
  logic [iop_pkg::ACC_BITS-1:0]  mem_wdata;
  logic [iop_pkg::SLOT_BITS-1:0] mem_raddr;
  logic [iop_pkg::ACC_BITS-1:0]  mem_rdata;
  logic                          scan_rd;

  // Scan pipeline: read data stage, then saturated count stage
  logic                          v1_q, last1_q;
  logic [iop_pkg::SLOT_BITS-1:0] slot1_q;
  logic                          v2_q, last2_q;
  logic [iop_pkg::SLOT_BITS-1:0] slot2_q;
  logic [iop_pkg::ACC_BITS-1:0]  acc_q;
  logic [iop_pkg::COUNT_BITS-1:0] sat_count;

  // Close the open plateau once the scan is done
  logic                          trk_finish;

  iop_pkg::iop_track_t trk;

  assign accept   = start && !busy;
  assign cnt_last = (cnt_q == iop_pkg::SLOT_BITS'(iop_pkg::TIME_SLOTS - 1));

  // Clip both bounds to the slot range; the interval is empty unless start < end
  always_comb begin
    start_clip = iop_pkg::CMP_BITS'(interval_start_i);
    end_clip   = iop_pkg::CMP_BITS'(interval_end_i);
    if (start_clip > iop_pkg::CMP_BITS'(iop_pkg::TIME_SLOTS)) begin
      start_clip = iop_pkg::CMP_BITS'(iop_pkg::TIME_SLOTS);
    end
    if (end_clip > iop_pkg::CMP_BITS'(iop_pkg::TIME_SLOTS)) begin
      end_clip = iop_pkg::CMP_BITS'(iop_pkg::TIME_SLOTS);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iop_pkg::ST_CLEAR: begin
        if (cnt_last) begin
          state_d = iop_pkg::ST_IDLE;
        end
      end
      iop_pkg::ST_IDLE: begin
        if (start) begin
          state_d = iop_pkg::ST_LOAD;
        end
      end
      iop_pkg::ST_LOAD:      state_d = iop_pkg::ST_ADD_START;
      iop_pkg::ST_ADD_START: state_d = iop_pkg::ST_SUB_END;
      iop_pkg::ST_SUB_END: begin
        state_d = last_q ? iop_pkg::ST_SCAN : iop_pkg::ST_IDLE;
      end
      iop_pkg::ST_SCAN: begin
        if (cnt_last) begin
          state_d = iop_pkg::ST_WAIT;
        end
      end
      iop_pkg::ST_WAIT: begin
        // Hold until the final slot has reached the tracker
        if (v2_q && last2_q) begin
          state_d = iop_pkg::ST_FINISH;
        end
      end
      iop_pkg::ST_FINISH: state_d = iop_pkg::ST_EMIT;
      iop_pkg::ST_EMIT:   state_d = iop_pkg::ST_IDLE;
      default:            state_d = iop_pkg::ST_IDLE;
    endcase
  end

  // Outputs and store port control
  always_comb begin
    busy           = 1'b1;
    result_valid_o = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cnt_q;
    mem_wdata      = '0;
    mem_raddr      = cnt_q;
    scan_rd        = 1'b0;
    trk_finish     = 1'b0;
    cnt_d          = '0;
    unique case (state_q)
      iop_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + iop_pkg::SLOT_BITS'(1);
      end
      iop_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      iop_pkg::ST_LOAD: begin
        mem_raddr = iop_pkg::SLOT_BITS'(start_q);
      end
      iop_pkg::ST_ADD_START: begin
        // Add one at the start slot, fetch the end slot
        mem_we    = nonempty_q;
        mem_waddr = iop_pkg::SLOT_BITS'(start_q);
        mem_wdata = mem_rdata + iop_pkg::ACC_BITS'(1);
        mem_raddr = iop_pkg::SLOT_BITS'(end_q);
      end
      iop_pkg::ST_SUB_END: begin
        // Drop the update when the end lies past the last slot
        mem_we    = nonempty_q && end_in_q;
        mem_waddr = iop_pkg::SLOT_BITS'(end_q);
        mem_wdata = mem_rdata - iop_pkg::ACC_BITS'(1);
      end
      iop_pkg::ST_SCAN: begin
        // Read each slot once and clear it behind the read
        mem_we  = 1'b1;
        scan_rd = 1'b1;
        cnt_d   = cnt_q + iop_pkg::SLOT_BITS'(1);
      end
      iop_pkg::ST_WAIT: begin
      end
      iop_pkg::ST_FINISH: begin
        trk_finish = 1'b1;
      end
      iop_pkg::ST_EMIT: begin
        result_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iop_pkg::ST_CLEAR;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= scan_rd;
      v2_q    <= v1_q;
    end
  end

  // Interval latch and scan pipeline payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      start_q    <= interval_start_i;
      end_q      <= interval_end_i;
      last_q     <= last_interval_i;
      nonempty_q <= (start_clip < end_clip);
      end_in_q   <= (end_clip < iop_pkg::CMP_BITS'(iop_pkg::TIME_SLOTS));
    end
    last1_q <= cnt_last;
    slot1_q <= cnt_q;
    last2_q <= last1_q;
    slot2_q <= slot1_q;
    if (v1_q) begin
      // Restart the running sum at slot zero
      acc_q <= ((slot1_q == '0) ? '0 : acc_q) + mem_rdata;
    end
  end

  // Saturate the running coverage to the count width
  always_comb begin
    if (acc_q > iop_pkg::ACC_BITS'(iop_pkg::COUNT_MAX)) begin
      sat_count = iop_pkg::COUNT_MAX;
    end else begin
      sat_count = acc_q[iop_pkg::COUNT_BITS-1:0];
    end
    trk.valid  = v2_q;
    trk.finish = trk_finish;
    trk.slot   = slot2_q;
    trk.count  = sat_count;
  end

  iop_delta_mem u_delta_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  iop_plateau u_plateau (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .trk_i        (trk),
    .best_count_o (peak_count_o),
    .best_left_o  (peak_left_o),
    .best_right_o (peak_right_o)
  );

endmodule
